// File: hw/rtl/lnf_pkg.sv
`timescale 1ns / 1ps
package lnf_pkg;

	// Sizes of the row and of the fields
	localparam int MAX_ROW_DEF = 64;
	localparam int ROWL_W      = 7;
	localparam int EPS_W       = 16;
	localparam int SMP_W       = 16;
	localparam int INV_W       = 24;
	localparam int ELEM_W      = 3 * SMP_W;

	// Arithmetic widths, sized for the largest row of 64 elements
	localparam int SUM_W   = 23;
	localparam int D_W     = 24;
	localparam int SQ_W    = 47;
	localparam int SUMSQ_W = 51;
	localparam int NN_W    = 14;
	localparam int N3_W    = 21;
	localparam int NUM_W   = 51;
	localparam int DEN_W   = 52;
	localparam int RAD_W   = 49;
	localparam int ROOT_W  = 25;
	localparam int P_W     = 49;
	localparam int T_W     = 34;

	localparam logic [NUM_W-1:0] ONE_Q48 = NUM_W'(1) << 48;

	// Configuration register indexes
	localparam int CFG_IDX_W = 2;
	localparam logic [CFG_IDX_W-1:0] REG_ROW_LENGTH = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EPSILON    = 2'd1;

	typedef struct packed {
		logic             start;
		logic [NUM_W-1:0] num;
		logic [DEN_W-1:0] den;
	} div_req_t;

	typedef struct packed {
		logic             done;
		logic [NUM_W-1:0] quo;
	} div_rsp_t;

endpackage

// File: hw/rtl/lnf_if.sv
`timescale 1ns / 1ps
// Element channel: one row element with its gain and bias per beat
interface lnf_in_if;
	import lnf_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] sample;
	logic signed [SMP_W-1:0] gain;
	logic signed [SMP_W-1:0] bias;
	modport source(output valid, sample, gain, bias, input ready);
	modport sink(input valid, sample, gain, bias, output ready);
endinterface

// Result channel: one normalized element per beat
interface lnf_out_if;
	import lnf_pkg::*;
	logic                    valid;
	logic                    ready;
	logic signed [SMP_W-1:0] normalized;
	logic signed [SMP_W-1:0] scaled;
	logic [INV_W-1:0]        inv_deviation;
	logic                    last;
	modport source(output valid, normalized, scaled, inv_deviation, last, input ready);
	modport sink(input valid, normalized, scaled, inv_deviation, last, output ready);
endinterface

// Register write channel
interface lnf_cfg_if;
	import lnf_pkg::*;
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [EPS_W-1:0]     data;
	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

// File: hw/rtl/lnf_ram.sv
`timescale 1ns / 1ps
module lnf_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 2
) (
	input  logic                                   clk,
	input  logic                                   we,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  logic [WIDTH-1:0]                       wdata,
	input  logic                                   re,
	input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                       rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end
endmodule

// File: hw/rtl/lnf_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit per cycle
module lnf_div (
	input  logic              clk,
	input  logic              arst_n,
	input  lnf_pkg::div_req_t req,
	output lnf_pkg::div_rsp_t rsp
);
	import lnf_pkg::*;

	localparam int CNT_W = $clog2(NUM_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DEN_W-1:0] rem_q;
	logic [DEN_W-1:0] den_q;
	logic [NUM_W-1:0] quo_q;
	logic [DEN_W:0]   trial;
	logic             ge;

	assign trial = {rem_q, quo_q[NUM_W-1]};
	assign ge    = trial >= {1'b0, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(NUM_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// datapath: shift in one numerator bit, subtract when it fits
	always_ff @(posedge clk) begin
		if (req.start) begin
			rem_q <= '0;
			den_q <= req.den;
			quo_q <= req.num;
		end else if (busy_q) begin
			rem_q <= ge ? DEN_W'(trial - {1'b0, den_q}) : trial[DEN_W-1:0];
			quo_q <= {quo_q[NUM_W-2:0], ge};
		end
	end

	assign rsp.done = done_q;
	assign rsp.quo  = quo_q;
endmodule

// File: hw/rtl/lnf_sqrt.sv
`timescale 1ns / 1ps
// Integer square root, two radicand bits per cycle
module lnf_sqrt (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic [lnf_pkg::RAD_W-1:0]   radicand,
	output logic                        done,
	output logic [lnf_pkg::ROOT_W-1:0]  root
);
	import lnf_pkg::*;

	localparam int RES_W = RAD_W + 1;
	localparam int CNT_W = $clog2(ROOT_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [RAD_W-1:0] rad_q;
	logic [RES_W-1:0] res_q;
	logic [RAD_W-1:0] bit_q;
	logic [RES_W-1:0] trial;
	logic             ge;

	assign trial = res_q + RES_W'(bit_q);
	assign ge    = RES_W'(rad_q) >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CNT_W'(ROOT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q <= radicand;
			res_q <= '0;
			bit_q <= RAD_W'(1) << (RAD_W - 1);
		end else if (busy_q) begin
			if (ge) begin
				rad_q <= RAD_W'(RES_W'(rad_q) - trial);
				res_q <= (res_q >> 1) + RES_W'(bit_q);
			end else begin
				res_q <= res_q >> 1;
			end
			bit_q <= bit_q >> 2;
		end
	end

	assign done = done_q;
	assign root = res_q[ROOT_W-1:0];
endmodule

// File: hw/rtl/layer_norm_forward_top.sv
`timescale 1ns / 1ps
// Flow: elements are taken only in the load state; the last element of a row of n
//   starts the row statistics, then the n results are computed one after another.
// The shared 51-step divider (variance, reciprocal and per-result scaling) and the
//   25-step root set the pace; the next row loads once the last result is emitted.
// Reset: arst_n clears the element count, running sum and control; row_length
//   returns to 64 and epsilon to 1. The element store is not cleared.
module layer_norm_forward_top #(
	parameter int MAX_ROW = lnf_pkg::MAX_ROW_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	lnf_in_if.sink   element,
	lnf_out_if.source result,
	lnf_cfg_if.sink  cfg
);
	import lnf_pkg::*;

	localparam int CW = $clog2(MAX_ROW + 1);
	localparam int AW = MAX_ROW > 1 ? $clog2(MAX_ROW) : 1;

	localparam logic [4:0] S_LOAD  = 5'd0;
	localparam logic [4:0] S_CUBE1 = 5'd1;
	localparam logic [4:0] S_CUBE2 = 5'd2;
	localparam logic [4:0] S_VRD   = 5'd3;
	localparam logic [4:0] S_VD    = 5'd4;
	localparam logic [4:0] S_VSQ   = 5'd5;
	localparam logic [4:0] S_VACC  = 5'd6;
	localparam logic [4:0] S_D1S   = 5'd7;
	localparam logic [4:0] S_D1W   = 5'd8;
	localparam logic [4:0] S_D2S   = 5'd9;
	localparam logic [4:0] S_D2W   = 5'd10;
	localparam logic [4:0] S_SQS   = 5'd11;
	localparam logic [4:0] S_SQW   = 5'd12;
	localparam logic [4:0] S_ORD   = 5'd13;
	localparam logic [4:0] S_OD    = 5'd14;
	localparam logic [4:0] S_OP    = 5'd15;
	localparam logic [4:0] S_ORND  = 5'd16;
	localparam logic [4:0] S_ODIV  = 5'd17;
	localparam logic [4:0] S_OG    = 5'd18;
	localparam logic [4:0] S_OEMIT = 5'd19;

	logic [4:0]               st_q;
	logic [ROWL_W-1:0]        row_length_q;
	logic [EPS_W-1:0]         eps_q;
	logic [CW-1:0]            count_q;
	logic signed [SUM_W-1:0]  sum_q;
	logic [ROWL_W-1:0]        n_q;
	logic signed [SUM_W-1:0]  s_q;
	logic [CW-1:0]            idx_q;
	logic [NN_W-1:0]          nn_q;
	logic [N3_W-1:0]          n3_q;
	logic signed [D_W-1:0]    d_s1;
	logic [SQ_W-1:0]          sq_q;
	logic [SUMSQ_W-1:0]       sumsq_q;
	logic [DEN_W-1:0]         v_q;
	logic [INV_W-1:0]         inv_q;
	logic signed [SMP_W-1:0]  g_q;
	logic signed [SMP_W-1:0]  b_q;
	logic                     psign_q;
	logic [P_W-1:0]           pmag_q;
	logic signed [SMP_W-1:0]  norm_q;
	logic signed [T_W-1:0]    t_q;
	logic                     ov_q;
	logic signed [SMP_W-1:0]  on_q;
	logic signed [SMP_W-1:0]  os_q;
	logic [INV_W-1:0]         oi_q;
	logic                     ol_q;

	logic                     take;
	logic [ROWL_W-1:0]        n_eff;
	logic [CW-1:0]            count_nxt;
	logic                     row_done;
	logic                     idx_last;
	logic                     emit;
	logic [ELEM_W-1:0]        rd_data;
	logic signed [SMP_W-1:0]  rd_sample;
	logic signed [D_W-1:0]    d_c;
	logic signed [2*D_W-1:0]  sq_c;
	logic [DEN_W-1:0]         v_c;
	logic signed [P_W-1:0]    p_c;
	logic [P_W-1:0]           m_c;
	logic [SMP_W:0]           qmag_c;
	logic signed [SMP_W-1:0]  norm_c;
	logic signed [T_W-1:0]    t_c;
	logic signed [T_W-1:0]    fl_c;
	logic signed [SMP_W-1:0]  scaled_c;
	logic                     sq_start;
	logic                     sq_done;
	logic [ROOT_W-1:0]        root;
	div_req_t                 div_req;
	div_rsp_t                 div_rsp;

	// Configuration registers, always writable
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_length_q <= ROWL_W'(64);
			eps_q        <= EPS_W'(1);
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_ROW_LENGTH: row_length_q <= cfg.data[ROWL_W-1:0];
				REG_EPSILON:    eps_q        <= cfg.data;
				default:        ;
			endcase
		end
	end

	// Effective row length, clamped to 1..MAX_ROW
	always_comb begin
		if (row_length_q == '0) begin
			n_eff = ROWL_W'(1);
		end else if (row_length_q > ROWL_W'(MAX_ROW)) begin
			n_eff = ROWL_W'(MAX_ROW);
		end else begin
			n_eff = row_length_q;
		end
	end

	assign element.ready = (st_q == S_LOAD);
	assign take          = element.valid && element.ready;
	assign count_nxt     = count_q + 1'b1;
	assign row_done      = ROWL_W'(count_nxt) >= n_eff;
	assign idx_last      = ROWL_W'(idx_q + 1'b1) == n_q;
	assign emit          = (st_q == S_OEMIT) && (!ov_q || result.ready);

	// Element store: {sample, gain, bias} per position
	lnf_ram #(
		.WIDTH(ELEM_W),
		.DEPTH(MAX_ROW)
	) u_store (
		.clk  (clk),
		.we   (take),
		.waddr(count_q[AW-1:0]),
		.wdata({element.sample, element.gain, element.bias}),
		.re   (st_q == S_VRD || st_q == S_ORD),
		.raddr(idx_q[AW-1:0]),
		.rdata(rd_data)
	);

	assign rd_sample = rd_data[ELEM_W-1 -: SMP_W];

	// Centered value n*x - S and its square
	assign d_c  = $signed({1'b0, n_q}) * rd_sample - s_q;
	assign sq_c = d_s1 * d_s1;
	assign v_c  = DEN_W'(div_rsp.quo) + DEN_W'(eps_q);

	// Output scaling: d * inv, rounded divide by n*4096
	assign p_c = d_s1 * $signed({1'b0, inv_q});
	assign m_c = pmag_q + (P_W'(n_q) << 11);

	// Clamp quotient magnitude, apply sign, saturate to 16 bits
	always_comb begin
		qmag_c = (div_rsp.quo > NUM_W'(65536)) ? (SMP_W + 1)'(65536)
			: div_rsp.quo[SMP_W:0];
		if (!psign_q) begin
			norm_c = (qmag_c > (SMP_W + 1)'(32767)) ? SMP_W'(32767) : qmag_c[SMP_W-1:0];
		end else begin
			norm_c = (qmag_c > (SMP_W + 1)'(32768)) ? SMP_W'(-32768)
				: SMP_W'(-$signed({1'b0, qmag_c}));
		end
	end

	assign t_c  = g_q * norm_q + ($signed(T_W'(b_q)) <<< 16) + T_W'(32768);
	assign fl_c = t_q >>> 16;

	always_comb begin
		if (fl_c > T_W'(32767)) begin
			scaled_c = SMP_W'(32767);
		end else if (fl_c < -T_W'(32768)) begin
			scaled_c = SMP_W'(-32768);
		end else begin
			scaled_c = fl_c[SMP_W-1:0];
		end
	end

	// Shared divider requests
	always_comb begin
		div_req.start = (st_q == S_D1S) || (st_q == S_D2S) || (st_q == S_ORND);
		unique case (st_q)
			S_D1S: begin
				div_req.num = sumsq_q;
				div_req.den = DEN_W'(n3_q);
			end
			S_D2S: begin
				div_req.num = ONE_Q48;
				div_req.den = v_q;
			end
			default: begin
				div_req.num = NUM_W'(m_c >> 12);
				div_req.den = DEN_W'(n_q);
			end
		endcase
	end

	lnf_div u_div (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (div_req),
		.rsp   (div_rsp)
	);

	assign sq_start = (st_q == S_SQS);

	lnf_sqrt u_sqrt (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (sq_start),
		.radicand(div_rsp.quo[RAD_W-1:0]),
		.done    (sq_done),
		.root    (root)
	);

	// Row sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q    <= S_LOAD;
			count_q <= '0;
			sum_q   <= '0;
			idx_q   <= '0;
			ov_q    <= 1'b0;
		end else begin
			// result register: loaded on emit, emptied when the beat leaves
			if (emit) begin
				ov_q <= 1'b1;
			end else if (result.ready) begin
				ov_q <= 1'b0;
			end
			unique case (st_q)
				S_LOAD: begin
					if (take) begin
						if (row_done) begin
							count_q <= '0;
							sum_q   <= '0;
							st_q    <= S_CUBE1;
						end else begin
							count_q <= count_nxt;
							sum_q   <= sum_q + SUM_W'(element.sample);
						end
					end
				end
				S_CUBE1: st_q <= S_CUBE2;
				S_CUBE2: begin
					idx_q <= '0;
					st_q  <= S_VRD;
				end
				S_VRD:   st_q <= S_VD;
				S_VD:    st_q <= S_VSQ;
				S_VSQ:   st_q <= S_VACC;
				S_VACC: begin
					idx_q <= idx_q + 1'b1;
					st_q  <= idx_last ? S_D1S : S_VRD;
				end
				S_D1S:   st_q <= S_D1W;
				S_D1W: begin
					if (div_rsp.done) begin
						if (v_c == '0) begin
							idx_q <= '0;
							st_q  <= S_ORD;
						end else begin
							st_q <= S_D2S;
						end
					end
				end
				S_D2S:   st_q <= S_D2W;
				S_D2W: begin
					if (div_rsp.done) begin
						st_q <= S_SQS;
					end
				end
				S_SQS:   st_q <= S_SQW;
				S_SQW: begin
					if (sq_done) begin
						idx_q <= '0;
						st_q  <= S_ORD;
					end
				end
				S_ORD:   st_q <= S_OD;
				S_OD:    st_q <= S_OP;
				S_OP:    st_q <= S_ORND;
				S_ORND:  st_q <= S_ODIV;
				S_ODIV: begin
					if (div_rsp.done) begin
						st_q <= S_OG;
					end
				end
				S_OG:    st_q <= S_OEMIT;
				S_OEMIT: begin
					if (emit) begin
						idx_q <= idx_q + 1'b1;
						st_q  <= idx_last ? S_LOAD : S_ORD;
					end
				end
				default: st_q <= S_LOAD;
			endcase
		end
	end

	// Row statistics and per-result datapath
	always_ff @(posedge clk) begin
		if (take && row_done) begin
			n_q <= ROWL_W'(count_nxt);
			s_q <= sum_q + SUM_W'(element.sample);
		end
		if (st_q == S_CUBE1) begin
			nn_q    <= NN_W'(n_q) * NN_W'(n_q);
			sumsq_q <= '0;
		end
		if (st_q == S_CUBE2) begin
			n3_q <= N3_W'(nn_q) * N3_W'(n_q);
		end
		if (st_q == S_VD || st_q == S_OD) begin
			d_s1 <= d_c;
		end
		if (st_q == S_OD) begin
			g_q <= rd_data[SMP_W +: SMP_W];
			b_q <= rd_data[SMP_W-1:0];
		end
		if (st_q == S_VSQ) begin
			sq_q <= sq_c[SQ_W-1:0];
		end
		if (st_q == S_VACC) begin
			sumsq_q <= sumsq_q + SUMSQ_W'(sq_q);
		end
		if (st_q == S_D1W && div_rsp.done) begin
			v_q <= v_c;
			if (v_c == '0) begin
				inv_q <= '1;
			end
		end
		if (st_q == S_SQW && sq_done) begin
			inv_q <= (root > ROOT_W'(24'hFFFFFF)) ? '1 : root[INV_W-1:0];
		end
		if (st_q == S_OP) begin
			psign_q <= p_c < 0;
			pmag_q  <= (p_c < 0) ? P_W'(-p_c) : P_W'(p_c);
		end
		if (st_q == S_ODIV && div_rsp.done) begin
			norm_q <= norm_c;
		end
		if (st_q == S_OG) begin
			t_q <= t_c;
		end
		if (emit) begin
			on_q <= norm_q;
			os_q <= scaled_c;
			oi_q <= inv_q;
			ol_q <= idx_last;
		end
	end

	assign result.valid         = ov_q;
	assign result.normalized    = on_q;
	assign result.scaled        = os_q;
	assign result.inv_deviation = oi_q;
	assign result.last          = ol_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q < CW'(MAX_ROW))
		else $error("element count passed the row capacity");

	a_row_start: assert property (@(posedge clk) disable iff (!arst_n)
		take && row_done |=> st_q == S_CUBE1 && count_q == '0)
		else $error("completed row did not start statistics");

	a_div_owner: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.done |-> st_q == S_D1W || st_q == S_D2W || st_q == S_ODIV)
		else $error("divider finished with no waiting request");

endmodule

// File: bench/tb.sv
`timescale 1ns / 1ps
module tb;
	import lnf_pkg::*;

	localparam int ROW_CAP = MAX_ROW_DEF;
	// index with no register behind it, must be ignored
	localparam logic [CFG_IDX_W-1:0] REG_NONE = 2'd2;
	localparam int LONG_HOLD = 600;
	localparam int SETTLE = 400;

	typedef struct {
		logic signed [SMP_W-1:0] sample;
		logic signed [SMP_W-1:0] gain;
		logic signed [SMP_W-1:0] bias;
	} elem_t;

	typedef struct {
		logic signed [SMP_W-1:0] normalized;
		logic signed [SMP_W-1:0] scaled;
		logic [INV_W-1:0]        inv_deviation;
		logic                    last;
	} norm_t;

	logic clk;
	logic arst_n;

	lnf_in_if  element();
	lnf_out_if result();
	lnf_cfg_if cfg();

	layer_norm_forward_top u_top (
		.clk    (clk),
		.arst_n (arst_n),
		.element(element.sink),
		.result (result.source),
		.cfg    (cfg.sink)
	);

	elem_t pending[$];
	norm_t norm_queue[$];
	int errors = 0;
	int items_sent = 0;
	int items_taken = 0;
	int hold_asked = 0;

	always #5 clk = ~clk;

	// ---------------- row predictor ----------------
	logic [ROWL_W-1:0]       row_len_reg;
	logic [EPS_W-1:0]        eps_reg;
	logic signed [SMP_W-1:0] smp_mem[ROW_CAP];
	logic signed [SMP_W-1:0] gain_mem[ROW_CAP];
	logic signed [SMP_W-1:0] bias_mem[ROW_CAP];
	int                      fill_count;
	longint                  row_sum;

	function automatic longint unsigned root48(longint unsigned q);
		longint unsigned r = 0;
		longint unsigned b = 64'd1 << 48;
		while (b != 0) begin
			if (q >= r + b) begin
				q = q - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	task automatic take_element(elem_t e);
		int n;
		int slot;
		longint d;
		longint p;
		longint t;
		longint nrm;
		longint unsigned sumsq;
		longint unsigned v;
		longint unsigned inv;
		longint unsigned mag;
		longint unsigned den;
		norm_t r;
		n = row_len_reg;
		if (n < 1) n = 1;
		if (n > ROW_CAP) n = ROW_CAP;
		slot = (fill_count >= ROW_CAP) ? ROW_CAP - 1 : fill_count;
		smp_mem[slot] = e.sample;
		gain_mem[slot] = e.gain;
		bias_mem[slot] = e.bias;
		row_sum += e.sample;
		fill_count = slot + 1;
		if (fill_count < n) return;
		// row complete: statistics over what arrived
		n = fill_count;
		sumsq = 0;
		for (int i = 0; i < n; i++) begin
			d = longint'(n) * smp_mem[i] - row_sum;
			sumsq += longint'(d * d);
		end
		v = sumsq / (longint'(n) * n * n) + eps_reg;
		if (v == 0) inv = 24'hFFFFFF;
		else begin
			inv = root48((64'd1 << 48) / v);
			if (inv > 24'hFFFFFF) inv = 24'hFFFFFF;
		end
		den = longint'(n) * 4096;
		for (int i = 0; i < n; i++) begin
			d = longint'(n) * smp_mem[i] - row_sum;
			p = d * longint'(inv);
			mag = (p < 0) ? longint'(-p) : longint'(p);
			mag = (mag + den / 2) / den;
			if (mag > 65536) mag = 65536;
			nrm = (p < 0) ? -longint'(mag) : longint'(mag);
			if (nrm > 32767) nrm = 32767;
			if (nrm < -32768) nrm = -32768;
			t = longint'(gain_mem[i]) * nrm + longint'(bias_mem[i]) * 65536 + 32768;
			t = t >>> 16;
			if (t > 32767) t = 32767;
			if (t < -32768) t = -32768;
			r.normalized = nrm[15:0];
			r.scaled = t[15:0];
			r.inv_deviation = inv[23:0];
			r.last = (i + 1 == n);
			norm_queue.push_back(r);
		end
		fill_count = 0;
		row_sum = 0;
	endtask

	// ---------------- monitor ----------------
	always @(posedge clk or negedge arst_n) begin
		norm_t x;
		if (!arst_n) begin
			row_len_reg = 7'd64;
			eps_reg = 16'd1;
			fill_count = 0;
			row_sum = 0;
		end else begin
			if (cfg.valid && cfg.ready) begin
				if (cfg.index == REG_ROW_LENGTH) row_len_reg = cfg.data[ROWL_W-1:0];
				else if (cfg.index == REG_EPSILON) eps_reg = cfg.data;
			end
			if (result.valid && result.ready) begin
				if (norm_queue.size() == 0) begin
					$display("%0t: unexpected result beat norm=%0d scaled=%0d inv=%0d last=%0b",
						$time, result.normalized, result.scaled, result.inv_deviation,
						result.last);
					errors++;
				end else begin
					x = norm_queue.pop_front();
					if (x.normalized !== result.normalized) begin
						$display("%0t: normalized expected %0d actual %0d", $time,
							x.normalized, result.normalized);
						errors++;
					end
					if (x.scaled !== result.scaled) begin
						$display("%0t: scaled expected %0d actual %0d", $time,
							x.scaled, result.scaled);
						errors++;
					end
					if (x.inv_deviation !== result.inv_deviation) begin
						$display("%0t: inv_deviation expected %0d actual %0d", $time,
							x.inv_deviation, result.inv_deviation);
						errors++;
					end
					if (x.last !== result.last) begin
						$display("%0t: last expected %0b actual %0b", $time,
							x.last, result.last);
						errors++;
					end
				end
			end
			if (element.valid && element.ready) begin
				take_element('{element.sample, element.gain, element.bias});
				items_taken++;
			end
		end
	end

	// ---------------- element driver: bursts and gaps ----------------
	int burst_left;
	int gap_left;
	always @(posedge clk or negedge arst_n) begin
		elem_t e;
		if (!arst_n) begin
			element.valid <= 1'b0;
			element.sample <= '0;
			element.gain <= '0;
			element.bias <= '0;
			burst_left = 4;
			gap_left = 0;
		end else if (!element.valid || element.ready) begin
			if (gap_left > 0) begin
				gap_left--;
				element.valid <= 1'b0;
			end else if (pending.size() > 0) begin
				e = pending.pop_front();
				element.valid <= 1'b1;
				element.sample <= e.sample;
				element.gain <= e.gain;
				element.bias <= e.bias;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 7);
				end
			end else begin
				element.valid <= 1'b0;
			end
		end
	end

	// ---------------- result sink: stall pattern and long hold ----------------
	int stall_mode;
	int mode_left;
	int hold_left;
	int hold_served;
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result.ready <= 1'b0;
			stall_mode = 0;
			mode_left = 0;
			hold_left = 0;
			hold_served = 0;
		end else begin
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(20, 200);
			end else mode_left--;
			if (hold_left == 0 && hold_served != hold_asked) begin
				hold_served = hold_asked;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				result.ready <= 1'b0;
			end else case (stall_mode)
				0: result.ready <= 1'b1;
				1: result.ready <= ($urandom_range(0, 3) != 0);
				default: result.ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ---------------- stimulus ----------------
	task automatic add_elem(logic [15:0] s, logic [15:0] g, logic [15:0] b);
		pending.push_back('{s, g, b});
		items_sent++;
	endtask

	// wait until every queued beat was taken and every expected result came back
	task automatic drain();
		while (items_taken != items_sent || norm_queue.size() > 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [15:0] val);
		cfg.valid <= 1'b1;
		cfg.index <= idx;
		cfg.data <= val;
		do @(posedge clk); while (!cfg.ready);
		cfg.valid <= 1'b0;
	endtask

	function automatic int eff_len(int rl);
		if (rl < 1) return 1;
		if (rl > ROW_CAP) return ROW_CAP;
		return rl;
	endfunction

	// one row: mostly wide random content, sometimes a tight cluster or a flat row
	task automatic add_row(int n);
		int style;
		logic [15:0] base;
		style = $urandom_range(0, 9);
		base = 16'($urandom);
		for (int i = 0; i < n; i++) begin
			if (style < 6) add_elem(16'($urandom), 16'($urandom), 16'($urandom));
			else if (style < 9)
				add_elem(base + 16'($urandom_range(0, 63)), 16'($urandom), 16'($urandom));
			else add_elem(base, 16'($urandom), 16'($urandom));
		end
	endtask

	initial begin
		int rl;
		int ep;
		int rows;
		clk = 1'b0;
		arst_n = 1'b0;
		cfg.valid = 1'b0;
		cfg.index = '0;
		cfg.data = '0;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// extremes of every field in one row of four
		write_reg(REG_ROW_LENGTH, 16'd4);
		add_elem(16'h7FFF, 16'h7FFF, 16'h7FFF);
		add_elem(16'h8000, 16'h8000, 16'h8000);
		add_elem(16'h0000, 16'h7FFF, 16'h8000);
		add_elem(16'h0001, 16'h8000, 16'h0000);
		drain();

		// flat row with zero offset: inverse deviation saturates
		write_reg(REG_EPSILON, 16'd0);
		write_reg(REG_ROW_LENGTH, 16'd2);
		add_elem(16'h1234, 16'h1000, 16'h0100);
		add_elem(16'h1234, 16'hF000, 16'hFF00);
		drain();

		// largest offset, and an ignored write to a missing register
		write_reg(REG_EPSILON, 16'hFFFF);
		write_reg(REG_NONE, 16'h0005);
		add_elem(16'h0100, 16'h1000, 16'h0000);
		add_elem(16'hFF00, 16'h1000, 16'h0000);
		drain();

		// zero length acts as one
		write_reg(REG_EPSILON, 16'd1);
		write_reg(REG_ROW_LENGTH, 16'd0);
		add_elem(16'h4000, 16'h2000, 16'h0010);
		add_elem(16'hC000, 16'h2000, 16'hFFF0);
		drain();

		// length shortened mid-row: row closes on the next element
		write_reg(REG_ROW_LENGTH, 16'd64);
		for (int i = 0; i < 10; i++) add_elem(16'($urandom), 16'($urandom), 16'($urandom));
		drain();
		write_reg(REG_ROW_LENGTH, 16'd4);
		add_elem(16'($urandom), 16'($urandom), 16'($urandom));
		drain();

		// oversize length acts as the full row
		write_reg(REG_ROW_LENGTH, 16'hFFFF);
		add_row(ROW_CAP);
		drain();

		// receiver holds off while the sender keeps going
		write_reg(REG_ROW_LENGTH, 16'd16);
		hold_asked++;
		for (int r = 0; r < 3; r++) add_row(16);
		drain();

		// random phases with fresh settings each time
		while (items_sent < 330) begin
			case ($urandom_range(0, 9))
				0: rl = 0;
				1: rl = 127;
				2: rl = 64;
				3: rl = $urandom_range(9, 32);
				default: rl = $urandom_range(1, 8);
			endcase
			case ($urandom_range(0, 5))
				0: ep = 0;
				1: ep = 65535;
				2: ep = $urandom;
				default: ep = $urandom_range(0, 255);
			endcase
			write_reg(REG_ROW_LENGTH, 16'(rl));
			write_reg(REG_EPSILON, 16'(ep));
			rows = (eff_len(rl) > 16) ? 1 : $urandom_range(2, 6);
			for (int r = 0; r < rows; r++) add_row(eff_len(rl));
			drain();
		end

		if (errors == 0) $display("tb: PASS");
		else $display("tb: FAIL");
		$finish;
	end

	initial begin
		#5ms;
		$display("tb: FAIL");
		$finish;
	end

endmodule

// File: sim.f
hw/rtl/lnf_pkg.sv
hw/rtl/lnf_if.sv
hw/rtl/lnf_ram.sv
hw/rtl/lnf_div.sv
hw/rtl/lnf_sqrt.sv
hw/rtl/layer_norm_forward_top.sv
bench/tb.sv
